// ===== sv/wbmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// WBMP type 0 decoder package
// Shared widths, codes, payload structs and the request struct that passes
// from the parser front end to the pixel expander.
// ----------------------------------------------------------------------------
package wbmpd_pkg;

    // Field parsing
    localparam int FIELD_BYTES = 4;
    localparam int ACC_W       = 7 * FIELD_BYTES;
    localparam int CNT_W       = $clog2(FIELD_BYTES + 1);

    // Image geometry
    localparam int DIM_W       = 17;
    localparam int COORD_W     = 16;
    localparam logic [DIM_W-1:0] IMG_LIMIT = 17'd65536;

    // Pixels per row byte
    localparam int PIX_PER_BYTE = 8;
    localparam int PIX_CNT_W    = $clog2(PIX_PER_BYTE + 1);
    localparam int PIX_IDX_W    = $clog2(PIX_PER_BYTE);

    // Request queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ACC_W-1:0] acc_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TOO_LONG  = 3'd1,
        ERR_TRUNCATED = 3'd2,
        ERR_BAD_TYPE  = 3'd3,
        ERR_BAD_SIZE  = 3'd4
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         pixel_value;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row_index;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [2:0]         error_code;
        logic               image_done;
        logic               last_of_run;
    } out_item_t;

    // One request: an optional header/error message or a pixel run,
    // followed by an optional truncation error.
    typedef struct packed {
        logic                 msg_valid;
        kind_t                msg_kind;
        err_t                 msg_err;
        logic [DIM_W-1:0]     img_w;
        logic [DIM_W-1:0]     img_h;
        logic [PIX_CNT_W-1:0] pix_cnt;
        logic [7:0]           pix_byte;
        logic [COORD_W-1:0]   pix_col;
        logic [COORD_W-1:0]   pix_row;
        logic                 pix_done;
        logic                 trunc;
    } cmd_t;

endpackage

// ===== sv/wbmp_type0_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// WBMP type 0 stream decoder
// Decodes a WBMP file byte stream into a header result, 8-bit pixels and
// error results.
//
//   Port group   Direction  Handshake       Payload
//   s_*          in         valid/ready     data_byte, end_of_file
//   m_*          out        valid/ready     kind .. last_of_run
//   cfg_*        in         write enable    max_dimension (17 bits)
//
// A byte is taken while the two-entry request queue has room; its request is queued,
// and each result is registered in the output register that drives m_valid. The
// expander sets the rate, one result per cycle unless m_ready stalls: per row byte, up
// to eight pixels and a truncation error if it ends the file early; per header byte, zero to two.
// Reset is synchronous and active low; max_dimension resets to 65536.
// A stalled m_ready holds the output register; the queue then fills and drops s_ready.
// ----------------------------------------------------------------------------
module wbmp_type0_stream_decoder_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [wbmpd_pkg::DIM_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  wbmpd_pkg::in_item_t         s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output wbmpd_pkg::out_item_t        m_data
);
    import wbmpd_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic head_valid;
    cmd_t head;
    logic pop;

    wbmpd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .push        (push),
        .push_cmd    (push_cmd),
        .q_full      (q_full)
    );

    wbmpd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    wbmpd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== sv/wbmpd_front.sv =====
// ----------------------------------------------------------------------------
// WBMP decoder front end
// Parses header fields, checks type and size, tracks row and column, and
// turns each input byte into at most one request for the expander.
// ----------------------------------------------------------------------------
module wbmpd_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [wbmpd_pkg::DIM_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  wbmpd_pkg::in_item_t         s_data,
    output logic                        push,
    output wbmpd_pkg::cmd_t             push_cmd,
    input  logic                        q_full
);
    import wbmpd_pkg::*;

    typedef enum logic [6:0] {
        PH_TYPE   = 7'b0000001,
        PH_FIX    = 7'b0000010,
        PH_WIDTH  = 7'b0000100,
        PH_HEIGHT = 7'b0001000,
        PH_PIXELS = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_ERROR  = 7'b1000000
    } phase_t;

    logic [DIM_W-1:0] max_dim_reg;
    phase_t           phase_reg, phase_next, phase_mid;
    acc_t             acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             type_nz_reg, type_nz_next;
    acc_t             width_reg, width_next;
    acc_t             height_reg, height_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;

    logic                 accept;
    logic [7:0]           b;
    acc_t                 acc_shift;
    logic [CNT_W-1:0]     cnt_inc;
    logic [DIM_W-1:0]     lim;
    acc_t                 lim_ext;
    logic [DIM_W-1:0]     wd;
    logic [DIM_W-1:0]     rem;
    logic [PIX_CNT_W-1:0] npix;
    logic [DIM_W-1:0]     col_end;
    logic [DIM_W-1:0]     row_inc;
    logic                 row_end;
    logic                 last_row;
    cmd_t                 cmd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.data_byte;

    // Shared arithmetic for field and pixel bytes
    assign acc_shift = acc_t'({acc_reg, b[6:0]});
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign lim       = (max_dim_reg < IMG_LIMIT) ? max_dim_reg : IMG_LIMIT;
    assign lim_ext   = ACC_W'(lim);
    assign wd        = width_reg[DIM_W-1:0];
    assign rem       = wd - col_reg;
    assign npix      = (rem >= DIM_W'(PIX_PER_BYTE)) ? PIX_CNT_W'(PIX_PER_BYTE)
                                                     : rem[PIX_CNT_W-1:0];
    assign col_end   = col_reg + DIM_W'(npix);
    assign row_inc   = row_reg + DIM_W'(1);
    assign row_end   = (col_end == wd);
    assign last_row  = (row_inc == height_reg[DIM_W-1:0]);

    // Parse one byte and build its request
    always_comb begin
        phase_mid    = phase_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        type_nz_next = type_nz_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        cmd          = '0;
        cmd.msg_kind = KIND_HEADER;
        cmd.msg_err  = ERR_NONE;

        if (accept) begin
            case (phase_reg)
                PH_TYPE, PH_WIDTH, PH_HEIGHT: begin
                    if (b[7]) begin
                        acc_next = acc_shift;
                        cnt_next = cnt_inc;
                        if (cnt_inc >= CNT_W'(FIELD_BYTES)) begin
                            cmd.msg_valid = 1'b1;
                            cmd.msg_kind  = KIND_ERROR;
                            cmd.msg_err   = ERR_TOO_LONG;
                            phase_mid     = PH_ERROR;
                        end
                    end else begin
                        acc_next = '0;
                        cnt_next = '0;
                        case (phase_reg)
                            PH_TYPE: begin
                                type_nz_next = (acc_shift != '0);
                                phase_mid    = PH_FIX;
                            end
                            PH_WIDTH: begin
                                width_next = acc_shift;
                                phase_mid  = PH_HEIGHT;
                            end
                            default: begin
                                height_next   = acc_shift;
                                cmd.msg_valid = 1'b1;
                                if (type_nz_reg) begin
                                    cmd.msg_kind = KIND_ERROR;
                                    cmd.msg_err  = ERR_BAD_TYPE;
                                    phase_mid    = PH_ERROR;
                                end else if (width_reg == '0 || acc_shift == '0 ||
                                             width_reg > lim_ext ||
                                             acc_shift > lim_ext) begin
                                    cmd.msg_kind = KIND_ERROR;
                                    cmd.msg_err  = ERR_BAD_SIZE;
                                    phase_mid    = PH_ERROR;
                                end else begin
                                    cmd.msg_kind = KIND_HEADER;
                                    cmd.img_w    = width_reg[DIM_W-1:0];
                                    cmd.img_h    = acc_shift[DIM_W-1:0];
                                    col_next     = '0;
                                    row_next     = '0;
                                    phase_mid    = PH_PIXELS;
                                end
                            end
                        endcase
                    end
                end
                PH_FIX: begin
                    phase_mid = PH_WIDTH;
                end
                PH_PIXELS: begin
                    cmd.pix_cnt  = npix;
                    cmd.pix_byte = b;
                    cmd.pix_col  = col_reg[COORD_W-1:0];
                    cmd.pix_row  = row_reg[COORD_W-1:0];
                    cmd.pix_done = row_end && last_row;
                    if (row_end) begin
                        col_next = '0;
                        row_next = row_inc;
                        if (last_row) begin
                            phase_mid = PH_DONE;
                        end
                    end else begin
                        col_next = col_end;
                    end
                end
                default: begin
                end
            endcase

            // End of file: flag an early end, then clear the parser
            if (s_data.end_of_file) begin
                cmd.trunc = (phase_mid == PH_TYPE) || (phase_mid == PH_FIX) ||
                            (phase_mid == PH_WIDTH) || (phase_mid == PH_HEIGHT) ||
                            (phase_mid == PH_PIXELS);
                phase_mid    = PH_TYPE;
                acc_next     = '0;
                cnt_next     = '0;
                type_nz_next = 1'b0;
                width_next   = '0;
                height_next  = '0;
                col_next     = '0;
                row_next     = '0;
            end
        end
        phase_next = phase_mid;
    end

    assign push     = accept && (cmd.msg_valid || (cmd.pix_cnt != '0) || cmd.trunc);
    assign push_cmd = cmd;

    // Hold parser state and the size limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dim_reg <= IMG_LIMIT;
            phase_reg   <= PH_TYPE;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            type_nz_reg <= 1'b0;
            width_reg   <= '0;
            height_reg  <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                max_dim_reg <= cfg_wr_data;
            end
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            type_nz_reg <= type_nz_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    a_eof_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.end_of_file |=> (phase_reg == PH_TYPE) && (cnt_reg == '0))
        else $error("parser not cleared after end of file");

    a_pix_geom: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PIXELS |-> (width_reg != '0) && (width_reg <= ACC_W'(IMG_LIMIT))
                                   && (col_reg < wd))
        else $error("pixel phase with bad geometry");

endmodule

// ===== sv/wbmpd_queue.sv =====
// ----------------------------------------------------------------------------
// WBMP decoder request queue
// Small register FIFO between the parser and the expander; the head is
// visible for the expander to work on in place.
// ----------------------------------------------------------------------------
module wbmpd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wbmpd_pkg::cmd_t push_cmd,
    output logic            full,
    output logic            head_valid,
    output wbmpd_pkg::cmd_t head,
    input  logic            pop
);
    import wbmpd_pkg::*;

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store requests
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("request popped from empty queue");

endmodule

// ===== sv/wbmpd_back.sv =====
// ----------------------------------------------------------------------------
// WBMP decoder expander
// Works through the queue head one result per cycle unless stalled: a header
// or error message, or up to eight pixels, then an optional truncation error.
// ----------------------------------------------------------------------------
module wbmpd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  wbmpd_pkg::cmd_t      head,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wbmpd_pkg::out_item_t m_data
);
    import wbmpd_pkg::*;

    typedef enum logic [1:0] {
        ST_MAIN  = 2'b01,
        ST_TRUNC = 2'b10
    } st_t;

    st_t                  st_reg, st_next;
    logic [PIX_IDX_W-1:0] idx_reg, idx_next;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    logic                 advance;
    logic                 fire;
    logic                 fin;
    logic                 last_pix;
    out_item_t            res;

    assign advance  = !m_valid_reg || m_ready;
    assign fire     = head_valid && advance;
    assign last_pix = ((PIX_CNT_W'(idx_reg) + PIX_CNT_W'(1)) == head.pix_cnt);

    // Pick the next result from the head request
    always_comb begin
        res      = '0;
        fin      = 1'b0;
        st_next  = st_reg;
        idx_next = idx_reg;
        case (st_reg)
            ST_MAIN: begin
                if (head.msg_valid) begin
                    res.kind         = head.msg_kind;
                    res.error_code   = head.msg_err;
                    res.image_width  = head.img_w;
                    res.image_height = head.img_h;
                    fin              = !head.trunc;
                    if (head.trunc) begin
                        st_next = ST_TRUNC;
                    end
                end else if (head.pix_cnt != '0) begin
                    res.kind        = KIND_PIXEL;
                    res.pixel_value = head.pix_byte[3'd7 - idx_reg] ? 8'hff : 8'h00;
                    res.column      = head.pix_col + COORD_W'(idx_reg);
                    res.row_index   = head.pix_row;
                    res.image_done  = head.pix_done && last_pix;
                    if (last_pix) begin
                        idx_next = '0;
                        fin      = !head.trunc;
                        if (head.trunc) begin
                            st_next = ST_TRUNC;
                        end
                    end else begin
                        idx_next = idx_reg + PIX_IDX_W'(1);
                    end
                end else begin
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TRUNCATED;
                    fin            = 1'b1;
                end
            end
            ST_TRUNC: begin
                res.kind       = KIND_ERROR;
                res.error_code = ERR_TRUNCATED;
                fin            = 1'b1;
                st_next        = ST_MAIN;
            end
            default: begin
                st_next = ST_MAIN;
            end
        endcase
        res.last_of_run = fin;
    end

    assign pop = fire && fin;

    // Output register and expansion progress
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_MAIN;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= head_valid;
            if (head_valid) begin
                st_reg  <= st_next;
                idx_reg <= idx_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_trunc_ends_request: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (st_reg == ST_TRUNC) |-> pop && (idx_reg == '0))
        else $error("truncation result did not close its request");

endmodule

// ===== test/tb_wbmp_type0_stream_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the WBMP type 0 stream decoder
// Feeds directed and random WBMP files, a byte per request, with random gaps
// on both channels and one long output stall. A local decoder model predicts
// every header, pixel and error result, and a checker compares them in order.
// ----------------------------------------------------------------------------
module tb_wbmp_type0_stream_decoder_top;
    import wbmpd_pkg::*;

    localparam int HOLDOFF_CYCLES = 150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_LIMIT   = 10;

    typedef enum logic [6:0] {
        PARSE_TYPE   = 7'b0000001,
        PARSE_FIXED  = 7'b0000010,
        PARSE_WIDTH  = 7'b0000100,
        PARSE_HEIGHT = 7'b0001000,
        PARSE_ROWS   = 7'b0010000,
        PARSE_DONE   = 7'b0100000,
        PARSE_ERROR  = 7'b1000000
    } parse_state_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [DIM_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;

    // Decoder model state
    parse_state_t     dec_state;
    acc_t             dec_acc;
    int unsigned      dec_field_len;
    logic             dec_type_nonzero;
    acc_t             dec_width;
    acc_t             dec_height;
    int unsigned      dec_col;
    int unsigned      dec_row;
    logic [DIM_W-1:0] dec_max_dim;

    out_item_t   decoded_results[$];
    logic [7:0]  file_bytes[$];
    int unsigned bytes_sent      = 0;
    int unsigned mismatch_count  = 0;
    int unsigned send_idle_pct   = 32;
    int unsigned ready_stall_pct = 32;
    logic        holdoff_req     = 1'b0;

    wbmp_type0_stream_decoder_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Clear the parser; the size limit survives
    function automatic void clear_decoder();
        dec_state        = PARSE_TYPE;
        dec_acc          = '0;
        dec_field_len    = 0;
        dec_type_nonzero = 1'b0;
        dec_width        = '0;
        dec_height       = '0;
        dec_col          = 0;
        dec_row          = 0;
    endfunction

    function automatic out_item_t error_result(input err_t code);
        out_item_t r;
        r = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        dec_state    = PARSE_ERROR;
        return r;
    endfunction

    // Advance the model by one accepted byte and queue the results it causes
    function automatic void decode_wbmp_byte(input logic [7:0] b, input logic eof);
        out_item_t        produced[$];
        out_item_t        r;
        acc_t             field_value;
        logic [DIM_W-1:0] lim;
        lim = (dec_max_dim < IMG_LIMIT) ? dec_max_dim : IMG_LIMIT;
        case (dec_state)
            PARSE_TYPE, PARSE_WIDTH, PARSE_HEIGHT: begin
                dec_acc = {dec_acc[ACC_W-8:0], b[6:0]};
                dec_field_len++;
                if (b[7]) begin
                    if (dec_field_len >= FIELD_BYTES)
                        produced.push_back(error_result(ERR_TOO_LONG));
                end else begin
                    field_value   = dec_acc;
                    dec_acc       = '0;
                    dec_field_len = 0;
                    if (dec_state == PARSE_TYPE) begin
                        dec_type_nonzero = (field_value != 0);
                        dec_state        = PARSE_FIXED;
                    end else if (dec_state == PARSE_WIDTH) begin
                        dec_width = field_value;
                        dec_state = PARSE_HEIGHT;
                    end else begin
                        dec_height = field_value;
                        // type is checked ahead of the size
                        if (dec_type_nonzero) begin
                            produced.push_back(error_result(ERR_BAD_TYPE));
                        end else if (dec_width < 1 || dec_height < 1 ||
                                     dec_width > lim || dec_height > lim) begin
                            produced.push_back(error_result(ERR_BAD_SIZE));
                        end else begin
                            r = '0;
                            r.kind         = KIND_HEADER;
                            r.image_width  = DIM_W'(dec_width);
                            r.image_height = DIM_W'(dec_height);
                            produced.push_back(r);
                            dec_col   = 0;
                            dec_row   = 0;
                            dec_state = PARSE_ROWS;
                        end
                    end
                end
            end
            PARSE_FIXED: dec_state = PARSE_WIDTH;
            PARSE_ROWS: begin
                // expand MSB first, drop the row padding
                for (int i = 7; i >= 0 && dec_col < dec_width; i--) begin
                    r = '0;
                    r.kind        = KIND_PIXEL;
                    r.pixel_value = b[i] ? 8'hFF : 8'h00;
                    r.column      = COORD_W'(dec_col);
                    r.row_index   = COORD_W'(dec_row);
                    r.image_done  = (dec_col + 1 == dec_width) && (dec_row + 1 == dec_height);
                    produced.push_back(r);
                    dec_col++;
                end
                if (dec_col >= dec_width) begin
                    dec_col = 0;
                    dec_row++;
                    if (dec_row >= dec_height)
                        dec_state = PARSE_DONE;
                end
            end
            default: ;
        endcase
        if (eof) begin
            if (dec_state <= PARSE_ROWS)
                produced.push_back(error_result(ERR_TRUNCATED));
            clear_decoder();
        end
        if (produced.size() > 0)
            produced[produced.size() - 1].last_of_run = 1'b1;
        foreach (produced[k])
            decoded_results.push_back(produced[k]);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic string result_text(input out_item_t r);
        return $sformatf("kind=%0d pix=%0d col=%0d row=%0d w=%0d h=%0d err=%0d done=%0b last=%0b",
                         r.kind, r.pixel_value, r.column, r.row_index, r.image_width,
                         r.image_height, r.error_code, r.image_done, r.last_of_run);
    endfunction

    function automatic void report_mismatch(input string what, input out_item_t want,
                                            input out_item_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] %s", $time, what);
            $display("    expected %s", result_text(want));
            $display("    actual   %s", result_text(got));
        end
    endfunction

    // Compare each taken result with the oldest prediction
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_results.size() == 0) begin
                report_mismatch("result with nothing expected", '0, m_data);
            end else begin
                want = decoded_results.pop_front();
                if (m_data.kind !== want.kind || m_data.pixel_value !== want.pixel_value ||
                    m_data.column !== want.column || m_data.row_index !== want.row_index ||
                    m_data.image_width !== want.image_width ||
                    m_data.image_height !== want.image_height ||
                    m_data.error_code !== want.error_code ||
                    m_data.image_done !== want.image_done ||
                    m_data.last_of_run !== want.last_of_run)
                    report_mismatch("result mismatch", want, m_data);
            end
        end
    end

    // Drive m_ready: random stalls, plus one long hold-off on request
    initial begin : drive_result_ready
        int held;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                m_ready <= 1'b0;
                for (held = 0; held < HOLDOFF_CYCLES; held++)
                    @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one request and hold it until it is taken
    task automatic send_byte(input logic [7:0] b, input logic eof);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, end_of_file: eof};
        do
            @(posedge aclk);
        while (!s_ready);
        decode_wbmp_byte(b, eof);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // Drop valid and wait until every predicted result is out
    task automatic drain_decoder();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (decoded_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_dimension(input logic [DIM_W-1:0] limit_value);
        drain_decoder();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit_value;
        @(posedge aclk);
        dec_max_dim = limit_value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int unsigned field_len(input acc_t v);
        if (v < 28'h80)
            return 1;
        if (v < 28'h4000)
            return 2;
        if (v < 28'h20_0000)
            return 3;
        return 4;
    endfunction

    // Big-endian 7-bit groups, continuation bit on all but the last
    function automatic void push_field(input acc_t v, input int unsigned len);
        for (int i = int'(len) - 1; i >= 0; i--)
            file_bytes.push_back({i != 0, 7'(v >> (7 * i))});
    endfunction

    // Mostly minimal encoding, sometimes padded with leading zero groups
    function automatic void push_random_field(input acc_t v);
        int unsigned need;
        need = field_len(v);
        push_field(v, ($urandom_range(99) < 70) ? need : $urandom_range(FIELD_BYTES, need));
    endfunction

    function automatic void push_overlong_field();
        repeat (FIELD_BYTES) file_bytes.push_back(8'h80 | 8'($urandom_range(127, 0)));
    endfunction

    // Mostly small sizes, some at or just above the limit, zero or anything 28 bits hold
    function automatic acc_t pick_dimension(input int unsigned common_hi);
        acc_t        lim;
        int unsigned r;
        lim = acc_t'((dec_max_dim < IMG_LIMIT) ? dec_max_dim : IMG_LIMIT);
        r   = $urandom_range(99);
        if (r < 75)
            return acc_t'($urandom_range(common_hi, 1));
        if (r < 85)
            return lim + acc_t'($urandom_range(1, 0));
        if (r < 92)
            return '0;
        return acc_t'($urandom_range(28'hFFF_FFFF, 0));
    endfunction

    // Build one file: mostly well formed, the rest truncated, bad or noise
    function automatic void build_random_file();
        acc_t            w;
        acc_t            h;
        int unsigned     mode;
        int unsigned     overlong_at;
        int unsigned     keep;
        longint unsigned row_total;
        file_bytes.delete();
        mode = $urandom_range(99);
        if (mode >= 88) begin
            repeat ($urandom_range(8, 1)) file_bytes.push_back(8'($urandom_range(255, 0)));
            return;
        end
        w = pick_dimension(20);
        h = pick_dimension(3);
        overlong_at = (mode >= 80) ? $urandom_range(2, 0) : 3;
        if (overlong_at == 0)
            push_overlong_field();
        else if (mode >= 72 && mode < 80)
            push_random_field(acc_t'($urandom_range(28'hFFF_FFFF, 1) >> $urandom_range(27, 0)));
        else
            push_field('0, $urandom_range(FIELD_BYTES, 1));
        file_bytes.push_back(8'($urandom_range(255, 0)));
        if (overlong_at == 1)
            push_overlong_field();
        else
            push_random_field(w);
        if (overlong_at == 2)
            push_overlong_field();
        else
            push_random_field(h);
        // rows; an image of over 24 row bytes gets only one to six before its end
        row_total = ((longint'(w) + 7) / 8) * longint'(h);
        if (row_total > 24)
            row_total = 64'($urandom_range(6, 1));
        repeat (row_total) file_bytes.push_back(8'($urandom_range(255, 0)));
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(2, 1)) file_bytes.push_back(8'($urandom_range(255, 0)));
        if (mode >= 64 && mode < 72 && file_bytes.size() > 1) begin
            keep = $urandom_range(file_bytes.size() - 1, 1);
            while (file_bytes.size() > keep)
                void'(file_bytes.pop_back());
        end
    endfunction

    task automatic run_random_files(input int unsigned item_budget);
        int unsigned first;
        first = bytes_sent;
        while (bytes_sent - first < item_budget) begin
            build_random_file();
            send_file();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // 10x1 image, padding bits set, one trailing byte that must be ignored
    task automatic test_basic_image();
        file_bytes = '{8'h00, 8'h00, 8'h0A, 8'h01, 8'hA5, 8'hFF, 8'h3C};
        send_file();
    endtask

    // Four continuation bytes in the type field, then silence up to the end
    task automatic test_overlong_field();
        file_bytes = '{8'h80, 8'hFF, 8'h80, 8'h81, 8'h00};
        send_file();
    endtask

    // Bad type wins over a bad size; then a zero width alone
    task automatic test_header_checks();
        file_bytes = '{8'h01, 8'hFF, 8'h00, 8'h00};
        send_file();
        file_bytes = '{8'h00, 8'h00, 8'h00, 8'h01};
        send_file();
    endtask

    // Widest allowed row, cut short after one byte
    task automatic test_widest_row_truncated();
        file_bytes.delete();
        push_field('0, 1);
        file_bytes.push_back(8'h00);
        push_field(acc_t'(IMG_LIMIT), 3);
        push_field(acc_t'(1), 1);
        file_bytes.push_back(8'h5A);
        send_file();
    endtask

    // Stall the output long enough for the request queue to fill up
    task automatic test_output_stall();
        send_idle_pct = 0;
        holdoff_req   = 1'b1;
        file_bytes = '{8'h00, 8'h00, 8'h10, 8'h03, 8'hF0, 8'h0F, 8'h81, 8'h7E, 8'hCC, 8'h33};
        send_file();
        send_idle_pct = 32;
    endtask

    task automatic test_random_reset_limit();
        run_random_files(40);
    endtask

    task automatic test_random_small_limit();
        write_max_dimension(17'd12);
        run_random_files(40);
    endtask

    task automatic test_random_limit_one();
        write_max_dimension(17'd1);
        run_random_files(30);
    endtask

    task automatic test_random_limit_zero();
        write_max_dimension(17'd0);
        run_random_files(25);
    endtask

    task automatic test_random_limit_above_cap();
        write_max_dimension(17'h1FFFF);
        run_random_files(40);
    endtask

    // Back-to-back requests with the output always ready
    task automatic test_random_no_idle();
        write_max_dimension(IMG_LIMIT);
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        run_random_files(40);
        send_idle_pct   = 32;
        ready_stall_pct = 32;
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        dec_max_dim = IMG_LIMIT;
        clear_decoder();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_image();
        test_overlong_field();
        test_header_checks();
        test_widest_row_truncated();
        test_output_stall();
        test_random_reset_limit();
        test_random_small_limit();
        test_random_limit_one();
        test_random_limit_zero();
        test_random_limit_above_cap();
        test_random_no_idle();

        drain_decoder();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
